// ===== sv/b64sc_pkg.sv =====
`default_nettype none
package b64sc_pkg;

  // Direction register codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Padding character '='
  localparam logic [7:0] PAD_CHAR = 8'd61;

  // Most results one input item can cause
  localparam int MAX_RESULTS = 4;

  // One result item
  typedef struct packed {
    logic [7:0] symbol;
    logic       present;
    logic       last;
  } result_t;

  // Decoded character: valid flag and 6-bit value
  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } char_val_t;

  // Map a 6-bit group to its alphabet character
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'd26) begin
      c = 8'd65 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      c = 8'd71 + {2'b00, idx};
    end else if (idx < 6'd62) begin
      c = {2'b00, idx} - 8'd4;
    end else if (idx == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

  // Map a character back to its 6-bit value; invalid for non-alphabet codes
  function automatic char_val_t b64_value(input logic [7:0] c);
    char_val_t r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (c >= 8'd65 && c <= 8'd90) begin
      t = c - 8'd65;
      r = '{valid: 1'b1, value: t[5:0]};
    end else if (c >= 8'd97 && c <= 8'd122) begin
      t = c - 8'd71;
      r = '{valid: 1'b1, value: t[5:0]};
    end else if (c >= 8'd48 && c <= 8'd57) begin
      t = c + 8'd4;
      r = '{valid: 1'b1, value: t[5:0]};
    end else if (c == 8'd43) begin
      r = '{valid: 1'b1, value: 6'd62};
    end else if (c == 8'd47) begin
      r = '{valid: 1'b1, value: 6'd63};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/base64_stream_codec.sv =====
`default_nettype none
// Channel     Direction  Payload
// s_axis      in         tdata[7:0] symbol_in, tlast message_end
// m_axis      out        tdata[7:0] symbol_out, tuser[0] data_present, tlast result_last
// cfg         in         cfg_wr_data: direction (0 encode, 1 decode)
//
// Each accepted item is worked out at once; its results (none to four) enter a four-entry
// buffer that drains one transaction per cycle into the output register while m_axis is not
// stalled, and a new item is taken once only the entry leaving this cycle remains.
// Encoding gives one or two characters per byte mid-message and up to four on the last byte.
// Synchronous reset clears direction, message state and all valid flags.
// A stall on m_axis holds the output register and blocks input while any result waits.
module base64_stream_codec
  import b64sc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] symbol_in
  input  wire logic       s_axis_tlast,   // message_end
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] symbol_out
  output logic [0:0]      m_axis_tuser,   // [0] data_present
  output logic            m_axis_tlast    // result_last
);

  localparam int IDX_W = $clog2(MAX_RESULTS);
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // Configuration and message state
  logic        direction;
  logic [11:0] bit_acc;
  logic [3:0]  pending;
  logic [1:0]  emit_cnt;
  logic        halted;

  logic [11:0] bit_acc_next;
  logic [3:0]  pending_next;
  logic [1:0]  emit_cnt_next;
  logic        halted_next;

  // Result buffer
  result_t          res_buf [MAX_RESULTS];
  logic [IDX_W-1:0] buf_head;
  logic [CNT_W-1:0] buf_rem;

  result_t          res_new [MAX_RESULTS];
  logic [CNT_W-1:0] res_n;

  logic accept;
  logic move;

  assign move          = (buf_rem != '0) && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = (buf_rem == '0) || ((buf_rem == CNT_W'(1)) && move);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Work out the results and next state for the item on the input
  always_comb begin
    logic [11:0] acc_w;
    logic [3:0]  p_w;
    logic [5:0]  idx1;
    logic [5:0]  idx2;
    logic        two;
    logic [2:0]  rem_bits;
    logic [5:0]  left_idx;
    logic [1:0]  cnt;
    logic [CNT_W-1:0] n;
    char_val_t   cv;

    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_new[i] = '0;
    end
    n        = '0;
    cnt      = emit_cnt;
    acc_w    = '0;
    p_w      = '0;
    idx1     = '0;
    idx2     = '0;
    two      = 1'b0;
    rem_bits = '0;
    left_idx = '0;
    cv       = '0;
    bit_acc_next  = bit_acc;
    pending_next  = pending;
    emit_cnt_next = emit_cnt;
    halted_next   = halted;

    if (direction == DIR_ENCODE) begin
      acc_w = {bit_acc[3:0], s_axis_tdata};
      p_w   = pending + 4'd8;
      priority case (p_w)
        4'd8: begin
          idx1 = acc_w[7:2]; rem_bits = 3'd2; left_idx = {acc_w[1:0], 4'b0000};
        end
        4'd10: begin
          idx1 = acc_w[9:4]; rem_bits = 3'd4; left_idx = {acc_w[3:0], 2'b00};
        end
        default: begin
          idx1 = acc_w[11:6]; idx2 = acc_w[5:0]; two = 1'b1; rem_bits = 3'd0;
        end
      endcase
      // Full 6-bit groups
      res_new[n[IDX_W-1:0]] = '{symbol: b64_char(idx1), present: 1'b1, last: 1'b0};
      n   = n + CNT_W'(1);
      cnt = cnt + 2'd1;
      if (two) begin
        res_new[n[IDX_W-1:0]] = '{symbol: b64_char(idx2), present: 1'b1, last: 1'b0};
        n   = n + CNT_W'(1);
        cnt = cnt + 2'd1;
      end
      if (s_axis_tlast) begin
        // Leftover bits, zero-padded
        if (rem_bits != '0) begin
          res_new[n[IDX_W-1:0]] = '{symbol: b64_char(left_idx), present: 1'b1, last: 1'b0};
          n   = n + CNT_W'(1);
          cnt = cnt + 2'd1;
        end
        // Pad to a multiple of four characters
        for (int k = 0; k < 3; k++) begin
          if (cnt != 2'd0 && n < CNT_W'(MAX_RESULTS)) begin
            res_new[n[IDX_W-1:0]] = '{symbol: PAD_CHAR, present: 1'b1, last: 1'b0};
            n   = n + CNT_W'(1);
            cnt = cnt + 2'd1;
          end
        end
        res_new[IDX_W'(n - CNT_W'(1))].last = 1'b1;
        bit_acc_next  = '0;
        pending_next  = '0;
        emit_cnt_next = '0;
        halted_next   = 1'b0;
      end else begin
        bit_acc_next  = acc_w;
        pending_next  = {1'b0, rem_bits};
        emit_cnt_next = cnt;
      end
    end else begin
      cv = b64_value(s_axis_tdata);
      if (!halted) begin
        if (!cv.valid) begin
          halted_next = 1'b1;
        end else begin
          acc_w = {bit_acc[5:0], cv.value};
          p_w   = pending + 4'd6;
          bit_acc_next = acc_w;
          pending_next = p_w;
          if (p_w >= 4'd8) begin
            priority case (p_w)
              4'd8:    res_new[0].symbol = acc_w[7:0];
              4'd10:   res_new[0].symbol = acc_w[9:2];
              default: res_new[0].symbol = acc_w[11:4];
            endcase
            res_new[0].present = 1'b1;
            res_new[0].last    = s_axis_tlast;
            n = CNT_W'(1);
            pending_next = p_w - 4'd8;
          end
        end
      end
      if (s_axis_tlast) begin
        // Bare end marker when no byte came out
        if (n == '0) begin
          res_new[0] = '{symbol: 8'd0, present: 1'b0, last: 1'b1};
          n = CNT_W'(1);
        end
        bit_acc_next  = '0;
        pending_next  = '0;
        emit_cnt_next = '0;
        halted_next   = 1'b0;
      end
    end
    res_n = n;
  end

  // Message state and direction register
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
      bit_acc   <= '0;
      pending   <= '0;
      emit_cnt  <= '0;
      halted    <= 1'b0;
    end else if (cfg_wr_en) begin
      direction <= cfg_wr_data;
      bit_acc   <= '0;
      pending   <= '0;
      emit_cnt  <= '0;
      halted    <= 1'b0;
    end else if (accept) begin
      bit_acc   <= bit_acc_next;
      pending   <= pending_next;
      emit_cnt  <= emit_cnt_next;
      halted    <= halted_next;
    end
  end

  // Load the result buffer and advance its head
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_head <= '0;
      buf_rem  <= '0;
    end else if (accept) begin
      buf_head <= '0;
      buf_rem  <= res_n;
    end else if (move) begin
      buf_head <= buf_head + IDX_W'(1);
      buf_rem  <= buf_rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_buf[i] <= res_new[i];
      end
    end
  end

  // Output register: take the head entry when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      m_axis_tdata    <= res_buf[buf_head].symbol;
      m_axis_tuser[0] <= res_buf[buf_head].present;
      m_axis_tlast    <= res_buf[buf_head].last;
    end
  end

endmodule
`default_nettype wire
